@@ rtl/l2d_pkg.sv @@
// ----------------------------------------------------------------------------
// l2d_pkg: shared types and constants of the Lanczos-2 decimator
// Holds the filter taps, the sequencer state type and the register indexes.
// ----------------------------------------------------------------------------
package l2d_pkg;

    localparam int unsigned TAPS = 8;

    typedef enum logic [1:0] {
        REG_DIRECTION = 2'd0,
        REG_WIDTH     = 2'd1,
        REG_HEIGHT    = 2'd2
    } t_reg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_OUT
    } t_state;

    // Tap k of the filter, Q1.15.
    function automatic logic signed [15:0] tap_coef(input logic [2:0] k);
        logic signed [15:0] c;
        case (k)
            3'd0, 3'd7: c = -16'sd295;
            3'd1, 3'd6: c = -16'sd1376;
            3'd2, 3'd5: c = 16'sd3834;
            default:    c = 16'sd14221;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/lanczos2_decimate_by_two.sv @@
// ----------------------------------------------------------------------------
// lanczos2_decimate_by_two: streaming 2:1 decimator with a Lanczos-2 filter
//
// Pixels arrive in raster order on the slave stream (s_axis_*); decimated
// samples leave on the master stream (m_axis_*). The direction register
// selects halving along rows (0) or along columns (1); image_width and
// image_height set the frame size and are clamped to 4..MAX. Any register
// write restarts the frame at the first pixel. Write registers only while
// the block is idle.
// Every pixel is written to a line store of eight rows. A pixel that
// completes the support of one or more outputs (at most two, at the far
// edge) starts the sequencer: each output reads its eight taps from the
// line store, one read per cycle, through a single multiply-accumulate
// unit. A pixel with no output leaves the sequencer idle, and each output
// passes through eight reads, a drain of the registered read and the
// registered multiply, and a handover of the sample to the output register.
// The single read port of the line store is why the taps are read in turn.
// The result waits in an output register. While the receiver stalls, the
// sequencer holds before handing over its next sample and s_axis_tready
// stays low until it is back in idle; a new pixel can be taken while the
// final sample of the previous one still waits. Reset clears the state,
// the raster counters, the configuration registers and the output valid
// flag but not the line store; each read hits an entry written earlier in the same frame.
// ----------------------------------------------------------------------------
module lanczos2_decimate_by_two #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024,
    parameter int unsigned PIXEL_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [PIXEL_BITS-1:0] pixel_value, zero fill to bytes
    input  logic [((PIXEL_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sample_value, out_col (10), out_row (10), end_of_image (1), zero fill
    output logic [((PIXEL_BITS+28)/8)*8-1:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import l2d_pkg::*;

    localparam int unsigned WB    = $clog2(MAX_WIDTH);
    localparam int unsigned HB    = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned CB    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned NB    = (HB > CB) ? HB : CB;
    localparam int unsigned DEPTH = 8 * MAX_WIDTH;
    localparam int unsigned AB    = $clog2(DEPTH);
    localparam int unsigned IW    = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int unsigned OW    = ((PIXEL_BITS + 28) / 8) * 8;

    t_state r_state, n_state;

    logic          r_vert;
    logic [10:0]   r_width, r_height;
    logic [NB-1:0] r_col, r_row;
    logic [NB-1:0] r_cur_col, r_cur_row;
    logic [NB-1:0] r_n;
    logic [NB-1:0] r_i, r_ihi;
    logic          r_lastpix;
    logic [3:0]    r_k;
    logic [1:0]    r_drain;
    logic          r_ovalid;
    logic [PIXEL_BITS-1:0] r_osample;
    logic [9:0]    r_ocol, r_orow;
    logic          r_olast, r_oeoi;

    logic [NB-1:0] w_eff, h_eff, n_now, p_now;
    logic [NB-1:0] ilo_now, ihi_now;
    logic          has_out;
    logic          in_xfer;
    logic [NB:0]   j_raw;
    logic [NB:0]   j_ref;
    logic [AB-1:0] raddr, waddr;
    logic [PIXEL_BITS-1:0] rdata;
    logic signed [PIXEL_BITS-1:0] mac_out;
    logic          mac_clear, mac_valid;
    logic [2:0]    r_tap_d;

    always_comb begin
        if (r_width < 11'd4) w_eff = NB'(4);
        else if (NB'(r_width) > NB'(MAX_WIDTH)) w_eff = NB'(MAX_WIDTH);
        else w_eff = NB'(r_width);
        if (r_height < 11'd4) h_eff = NB'(4);
        else if (NB'(r_height) > NB'(MAX_HEIGHT)) h_eff = NB'(MAX_HEIGHT);
        else h_eff = NB'(r_height);
        n_now = r_vert ? h_eff : w_eff;
        p_now = r_vert ? r_row : r_col;
        if (p_now == n_now - NB'(1)) begin
            ilo_now = (n_now - NB'(4)) >> 1;
            ihi_now = n_now >> 1;
            has_out = 1'b1;
        end else if (p_now >= NB'(4) && !p_now[0]) begin
            ilo_now = (p_now - NB'(4)) >> 1;
            ihi_now = ilo_now + NB'(1);
            has_out = 1'b1;
        end else begin
            ilo_now = '0;
            ihi_now = '0;
            has_out = 1'b0;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE) && !i_cfg_we;
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // Tap address: source 2i+k-3 reflected into 0..n-1.
    always_comb begin
        j_raw = {r_i, 1'b0} + (NB+1)'(r_k) - (NB+1)'(3);
        j_ref = j_raw;
        if (j_raw[NB]) j_ref = -j_raw;
        if (j_ref >= {1'b0, r_n}) j_ref = {r_n, 1'b0} - (NB+1)'(1) - j_ref;
        if (r_vert) raddr = {j_ref[2:0], r_cur_col[WB-1:0]};
        else raddr = AB'(j_ref[2:0]);
        if (r_vert) waddr = {r_row[2:0], r_col[WB-1:0]};
        else waddr = AB'(r_col[2:0]);
    end

    l2d_ram #(.WIDTH(PIXEL_BITS), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (in_xfer),
        .i_waddr (waddr),
        .i_wdata (s_axis_tdata[PIXEL_BITS-1:0]),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign mac_clear = (r_state == ST_IDLE) || (r_state == ST_OUT && !r_ovalid);

    l2d_mac #(.PIXEL_BITS(PIXEL_BITS)) u_mac (
        .i_clk    (i_clk),
        .i_clear  (mac_clear),
        .i_valid  (mac_valid),
        .i_sample (rdata),
        .i_tap    (r_tap_d),
        .o_result (mac_out)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (in_xfer && has_out) n_state = ST_READ;
            ST_READ:  if (r_k == 4'(TAPS - 1)) n_state = ST_DRAIN;
            ST_DRAIN: if (r_drain == 2'd1) n_state = ST_OUT;
            ST_OUT: begin
                if (!r_ovalid) begin
                    n_state = (r_i + NB'(1) == r_ihi) ? ST_IDLE : ST_READ;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_vert   <= 1'b0;
            r_width  <= 11'd1024;
            r_height <= 11'd1024;
            r_col    <= '0;
            r_row    <= '0;
            r_ovalid <= 1'b0;
            mac_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            mac_valid <= (r_state == ST_READ);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_DIRECTION: r_vert   <= i_cfg_data[0];
                    REG_WIDTH:     r_width  <= i_cfg_data;
                    REG_HEIGHT:    r_height <= i_cfg_data;
                    default:       ;
                endcase
                if (i_cfg_index inside {REG_DIRECTION, REG_WIDTH, REG_HEIGHT}) begin
                    r_col <= '0;
                    r_row <= '0;
                end
            end else if (in_xfer) begin
                if (r_col == w_eff - NB'(1)) begin
                    r_col <= '0;
                    r_row <= (r_row == h_eff - NB'(1)) ? '0 : r_row + NB'(1);
                end else begin
                    r_col <= r_col + NB'(1);
                end
            end
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (r_state == ST_OUT && !r_ovalid) r_ovalid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tap_d <= r_k[2:0];
        if (in_xfer) begin
            r_cur_col <= r_col;
            r_cur_row <= r_row;
            r_n       <= n_now;
            r_i       <= ilo_now;
            r_ihi     <= ihi_now;
            r_lastpix <= (r_col == w_eff - NB'(1)) && (r_row == h_eff - NB'(1));
            r_k       <= '0;
        end
        if (r_state == ST_READ) r_k <= r_k + 4'd1;
        r_drain <= (r_state == ST_READ) ? 2'd0 : r_drain + 2'd1;
        if (r_state == ST_OUT && !r_ovalid) begin
            r_osample <= mac_out;
            r_ocol    <= r_vert ? r_cur_col[9:0] : r_i[9:0];
            r_orow    <= r_vert ? r_i[9:0] : r_cur_row[9:0];
            r_olast   <= (r_i + NB'(1) == r_ihi);
            r_oeoi    <= r_lastpix && (r_i + NB'(1) == r_ihi);
            r_i       <= r_i + NB'(1);
            r_k       <= '0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = OW'({r_oeoi, r_orow, r_ocol, r_osample});

    logic unused_in;
    assign unused_in = ^s_axis_tdata[IW-1:0] | ^r_cur_row[NB-1:NB-1];
endmodule

@@ rtl/l2d_ram.sv @@
// ----------------------------------------------------------------------------
// l2d_ram: generic single-port-write, single-port-read RAM
// Synchronous write, registered read: data appear in the cycle after the address.
// ----------------------------------------------------------------------------
module l2d_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/l2d_mac.sv @@
// ----------------------------------------------------------------------------
// l2d_mac: multiply-accumulate unit with rounding and saturation
// Takes one tap per cycle, keeps a running sum and rounds it at the end.
// ----------------------------------------------------------------------------
module l2d_mac #(
    parameter int unsigned PIXEL_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_clear,
    input  logic                         i_valid,
    input  logic signed [PIXEL_BITS-1:0] i_sample,
    input  logic [2:0]                   i_tap,
    output logic signed [PIXEL_BITS-1:0] o_result
);
    import l2d_pkg::*;

    localparam int unsigned PW = PIXEL_BITS + 16;
    localparam int unsigned AW = PW + 4;

    logic signed [PW-1:0] r_prod;
    logic                 r_pvalid;
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] rounded;
    logic signed [AW-16:0] shifted;
    logic signed [AW-16:0] hi_lim;
    logic signed [AW-16:0] lo_lim;

    always_ff @(posedge i_clk) begin
        r_prod   <= PW'(i_sample * tap_coef(i_tap));
        r_pvalid <= i_valid;
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_pvalid) begin
            r_acc <= r_acc + AW'(r_prod);
        end
    end

    always_comb begin
        rounded = r_acc + AW'(16384);
        shifted = rounded[AW-1:15];
        hi_lim  = (AW-15)'({1'b0, {(PIXEL_BITS-1){1'b1}}});
        lo_lim  = -hi_lim - (AW-15)'(1);
        if (shifted > hi_lim) begin
            o_result = {1'b0, {(PIXEL_BITS-1){1'b1}}};
        end else if (shifted < lo_lim) begin
            o_result = {1'b1, {(PIXEL_BITS-1){1'b0}}};
        end else begin
            o_result = shifted[PIXEL_BITS-1:0];
        end
    end
endmodule

@@ rtl/l2d_checker.sv @@
// ----------------------------------------------------------------------------
// l2d_checker: port-level checks of the decimator
// Watches the two streams and the configuration port.
// ----------------------------------------------------------------------------
module l2d_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_cfg_we,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tlast
);
    // The output is held while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output dropped while stalled");

    // The last-of-run marker does not change while a transfer waits.
    a_last_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast))
        else $error("tlast changed while output stalled");

    // No input during a configuration write.
    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !s_axis_tready)
        else $error("input taken during config write");

    // Valid output after reset is never immediate.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule

bind lanczos2_decimate_by_two l2d_checker u_l2d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast)
);

@@ sim/tb_lanczos2_decimate_by_two.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lanczos2_decimate_by_two: self-checking bench of the Lanczos-2 decimator
//
// Drives pixel transfers into the slave stream and collects decimated
// samples from the master stream. Both sides insert random idle cycles.
// A behavioral predictor written here keeps its own copy of the counters,
// the registers and the line store. It computes every sample that a pixel
// causes, and each received sample is compared field by field against the
// oldest prediction. A short directed table comes first. Random image
// phases follow, over small sizes, both directions, clamped sizes and a
// short run at a width clamped to the maximum.
// ----------------------------------------------------------------------------
module tb_lanczos2_decimate_by_two;
    import l2d_pkg::*;

    localparam int unsigned MAXW = 1024;
    localparam int unsigned MAXH = 1024;
    localparam int          DRAIN_CYCLES = 60;
    localparam int          RANDOM_ITEMS = 134;

    // One decimated sample as it leaves the block.
    typedef struct packed {
        logic [15:0] sample;
        logic [9:0]  col;
        logic [9:0]  row;
        logic        last;
        logic        eoi;
    } t_sample;

    // One row of the directed table: a register write or a pixel.
    // Where known_val is set, every sample that the pixel causes must equal
    // known_sample; otherwise the predictor decides.
    typedef struct {
        bit          is_cfg;
        t_reg_index  idx;
        logic [10:0] cfg_val;
        logic [15:0] pix;
        bit          known_val;
        logic [15:0] known_sample;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [10:0] i_cfg_data = 11'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [15:0] pixel_value
    logic [15:0] s_axis_tdata = 16'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [15:0] sample_value, [25:16] out_col, [35:26] out_row,
    // [36] end_of_image, [39:37] zero fill
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    lanczos2_decimate_by_two i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: registers, raster position and line store.
    logic        pred_vertical;
    logic [10:0] pred_width_reg;
    logic [10:0] pred_height_reg;
    int unsigned pred_col;
    int unsigned pred_row;
    int          line_rows [8*MAXW];

    t_sample     pending_samples [$];
    int          mismatch_count = 0;
    int          pixels_sent = 0;
    int          samples_seen = 0;
    int          frames_done = 0;
    bit          idle_free = 1'b0;   // when set, neither side idles

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    function automatic int unsigned clamp_dim(input logic [10:0] v, input int unsigned maxv);
        if (v < 4) return 4;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int tap_weight(input int k);
        case (k)
            0, 7:    return -295;
            1, 6:    return -1376;
            2, 5:    return 3834;
            default: return 14221;
        endcase
    endfunction

    function automatic int mirror_index(input int j, input int n);
        if (j < 0) j = -j;
        if (j >= n) j = 2 * n - 1 - j;
        return j;
    endfunction

    // Filtered, rounded and saturated sample i along a dimension of length n.
    function automatic logic [15:0] lanczos_sample(input int i, input int n,
                                                   input int col, input bit vert);
        longint acc;
        longint v;
        int     j;
        int     addr;
        acc = 0;
        for (int k = 0; k < 8; k++) begin
            j = mirror_index(2 * i + k - 3, n);
            addr = vert ? ((j & 7) * MAXW + col) : (j & 7);
            acc += longint'(line_rows[addr]) * tap_weight(k);
        end
        v = (acc + 16384) >>> 15;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // Store one pixel and queue every sample it completes.
    task automatic predict_pixel(input logic [15:0] pix, input bit known_val,
                                 input logic [15:0] known_sample);
        int unsigned w, h, n, p, ilo, ihi;
        bit          vert, last_pixel;
        t_sample     s;
        w = clamp_dim(pred_width_reg, MAXW);
        h = clamp_dim(pred_height_reg, MAXH);
        vert = pred_vertical;
        n = vert ? h : w;
        p = vert ? pred_row : pred_col;
        last_pixel = (pred_col == w - 1) && (pred_row == h - 1);
        if (vert) line_rows[(pred_row & 7) * MAXW + pred_col] = int'($signed(pix));
        else line_rows[pred_col & 7] = int'($signed(pix));
        // The final pixel of a run flushes the edge samples; otherwise
        // every even pixel from the fifth on completes one sample.
        if (p == n - 1) begin
            ilo = (n - 4) / 2;
            ihi = n / 2;
        end else if (p >= 4 && p[0] == 1'b0) begin
            ilo = (p - 4) / 2;
            ihi = ilo + 1;
        end else begin
            ilo = 0;
            ihi = 0;
        end
        for (int unsigned i = ilo; i < ihi; i++) begin
            s.sample = known_val ? known_sample : lanczos_sample(i, n, pred_col, vert);
            s.col    = vert ? 10'(pred_col) : 10'(i);
            s.row    = vert ? 10'(i) : 10'(pred_row);
            s.last   = (i + 1 == ihi);
            s.eoi    = last_pixel && (i + 1 == ihi);
            pending_samples.push_back(s);
        end
        if (last_pixel) frames_done++;
        pred_col++;
        if (pred_col >= w) begin
            pred_col = 0;
            pred_row++;
            if (pred_row >= h) pred_row = 0;
        end
    endtask

    function automatic int idle_draw();
        return idle_free ? 0 : $urandom_range(0, 3);
    endfunction

    // One pixel transfer. Valid stays high into the next pixel when that
    // one draws no gap, so it is never dropped and raised in one step.
    task automatic send_pixel(input logic [15:0] pix, input bit known_val,
                              input logic [15:0] known_sample);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_pixel(pix, known_val, known_sample);
        pixels_sent++;
    endtask

    // Register writes happen only with the block idle: all samples back and
    // enough cycles passed for a pixel that produced nothing to retire.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_index idx, input logic [10:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            REG_DIRECTION: pred_vertical   = val[0];
            REG_WIDTH:     pred_width_reg  = val;
            default:       pred_height_reg = val;
        endcase
        pred_col = 0;
        pred_row = 0;
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
    endtask

    // Receiver: random stalls, then compares each transfer with the oldest
    // prediction.
    initial begin : sample_checker
        int      stall;
        t_sample got;
        t_sample want;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = idle_draw();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.sample = m_axis_tdata[15:0];
            got.col    = m_axis_tdata[25:16];
            got.row    = m_axis_tdata[35:26];
            got.eoi    = m_axis_tdata[36];
            got.last   = m_axis_tlast;
            samples_seen++;
            if (pending_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected sample %h", got));
            end else begin
                want = pending_samples.pop_front();
                if (got.sample !== want.sample)
                    report_mismatch($sformatf("sample %h, want %h (col %0d row %0d)",
                                              got.sample, want.sample, want.col, want.row));
                if (got.col !== want.col)
                    report_mismatch($sformatf("out_col %0d, want %0d", got.col, want.col));
                if (got.row !== want.row)
                    report_mismatch($sformatf("out_row %0d, want %0d", got.row, want.row));
                if (got.last !== want.last)
                    report_mismatch($sformatf("tlast %b, want %b at col %0d row %0d",
                                              got.last, want.last, want.col, want.row));
                if (got.eoi !== want.eoi)
                    report_mismatch($sformatf("end_of_image %b, want %b at col %0d row %0d",
                                              got.eoi, want.eoi, want.col, want.row));
            end
        end
    end

    // Generous bound: the slowest legal run is well under a tenth of this.
    initial begin : watchdog
        #20_000_000;
        $display("lanczos2_decimate_by_two verification failed");
        $finish;
    end

    initial begin : stimulus
        t_row        dir_rows [$];
        t_row        r;
        int unsigned w, h, npix;
        logic [10:0] wv, hv;
        logic [15:0] pix;
        int          random_pixels;

        pred_vertical   = 1'b0;
        pred_width_reg  = 11'd1024;
        pred_height_reg = 11'd1024;
        pred_col = 0;
        pred_row = 0;
        foreach (line_rows[k]) line_rows[k] = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: a 4x4 horizontal frame. A flat row passes through
        // unchanged since the taps sum to one, so the two flat rows at the
        // positive and negative limits have samples known by inspection. The
        // alternating rows are checked against the predictor. The height
        // write of 1 exercises the clamp to the minimum size.
        r = '{is_cfg: 1'b0, idx: REG_DIRECTION, cfg_val: '0, pix: '0,
              known_val: 1'b0, known_sample: '0};
        r.is_cfg = 1'b1;
        r.idx = REG_DIRECTION; r.cfg_val = 11'd0;    dir_rows.push_back(r);
        r.idx = REG_WIDTH;     r.cfg_val = 11'd4;    dir_rows.push_back(r);
        r.idx = REG_HEIGHT;    r.cfg_val = 11'd1;    dir_rows.push_back(r);
        r = '{is_cfg: 1'b0, idx: REG_DIRECTION, cfg_val: '0, pix: '0,
              known_val: 1'b0, known_sample: '0};
        for (int k = 0; k < 16; k++) begin
            case (k / 4)
                0:       begin r.pix = 16'h7fff; r.known_val = 1'b1; end
                1:       begin r.pix = 16'h8000; r.known_val = 1'b1; end
                2:       begin r.pix = k[0] ? 16'h8000 : 16'h7fff; r.known_val = 1'b0; end
                default: begin r.pix = k[0] ? 16'h7fff : 16'h8000; r.known_val = 1'b0; end
            endcase
            r.known_sample = r.pix;
            dir_rows.push_back(r);
        end

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                wait_idle();
                write_reg(dir_rows[k].idx, dir_rows[k].cfg_val);
                end_writes();
            end else begin
                send_pixel(dir_rows[k].pix, dir_rows[k].known_val,
                           dir_rows[k].known_sample);
            end
        end

        // Random phases. Phase 0 is a short run at a width reached through a
        // clamped write of the largest register value. Later phases send a
        // random share of a small frame, sometimes past its end, so later
        // writes also restart a partly sent frame.
        random_pixels = 0;
        for (int ph = 0; random_pixels < RANDOM_ITEMS; ph++) begin
            wait_idle();
            idle_free = ($urandom_range(0, 4) == 0);
            if (ph == 0) begin
                wv = 11'd2047;
                hv = 11'd4;
            end else begin
                wv = ($urandom_range(0, 5) == 0) ? 11'($urandom_range(0, 3))
                                                 : 11'($urandom_range(4, 8));
                hv = ($urandom_range(0, 5) == 0) ? 11'($urandom_range(0, 3))
                                                 : 11'($urandom_range(4, 8));
            end
            write_reg(REG_HEIGHT, hv);
            write_reg(REG_DIRECTION, 11'($urandom_range(0, 1)));
            write_reg(REG_WIDTH, wv);
            end_writes();
            w = clamp_dim(wv, MAXW);
            h = clamp_dim(hv, MAXH);
            if (ph == 0) npix = 12;
            else npix = $urandom_range(w, w * h + w);
            if (npix > int'(RANDOM_ITEMS - random_pixels))
                npix = int'(RANDOM_ITEMS - random_pixels);
            for (int k = 0; k < npix; k++) begin
                case ($urandom_range(0, 7))
                    0:       pix = 16'h7fff;
                    1:       pix = 16'h8000;
                    2, 3:    pix = 16'($urandom_range(0, 511)) - 16'd256;
                    default: pix = 16'($urandom);
                endcase
                send_pixel(pix, 1'b0, 16'h0);
                random_pixels++;
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d pixels over %0d complete frames, checked %0d samples.",
                 pixels_sent, frames_done, samples_seen);
        $display("Both directions, clamped sizes and a width clamped to the maximum ran.");
        if (mismatch_count == 0 && pending_samples.size() == 0) begin
            $display("lanczos2_decimate_by_two verification clean");
        end else begin
            $display("lanczos2_decimate_by_two verification failed");
        end
        $finish;
    end

endmodule
